[rtl/rtc_pkg.sv]
// rtc_pkg: types, codes and constants for the real-time clock and calendar core
// no dependencies; used by rtc_stream_if users and rtc_time_and_calendar_core

package rtc_pkg;

  localparam int unsigned TpsWidth = 16;
  localparam int unsigned HourWidth = 5;
  localparam int unsigned MinWidth = 6;
  localparam int unsigned SecWidth = 6;
  localparam int unsigned DayWidth = 5;
  localparam int unsigned MonthWidth = 4;
  localparam int unsigned YearWidth = 7;

  localparam logic [TpsWidth-1:0] TpsReset = 16'd1000;
  localparam logic [DayWidth-1:0] DayReset = 5'd26;
  localparam logic [MonthWidth-1:0] MonthReset = 4'd7;
  localparam logic [YearWidth-1:0] YearReset = 7'd25;

  localparam logic [SecWidth-1:0] LastSec = 6'd59;
  localparam logic [MinWidth-1:0] LastMin = 6'd59;
  localparam logic [HourWidth-1:0] LastHour = 5'd23;
  localparam logic [MonthWidth-1:0] LastMonth = 4'd12;
  localparam logic [YearWidth-1:0] LastYear = 7'd99;

  localparam logic [MonthWidth-1:0] MonthFeb = 4'd2;
  localparam logic [MonthWidth-1:0] MonthApr = 4'd4;
  localparam logic [MonthWidth-1:0] MonthJun = 4'd6;
  localparam logic [MonthWidth-1:0] MonthSep = 4'd9;
  localparam logic [MonthWidth-1:0] MonthNov = 4'd11;

  typedef enum logic [1:0] {
    FuncTick    = 2'd0,
    FuncSetTime = 2'd1,
    FuncSetDate = 2'd2
  } rtc_func_e;

  typedef struct packed {
    logic [1:0]            func;
    logic [HourWidth-1:0]  set_hour;
    logic [MinWidth-1:0]   set_minute;
    logic [SecWidth-1:0]   set_second;
    logic [DayWidth-1:0]   set_day;
    logic [MonthWidth-1:0] set_month;
    logic [YearWidth-1:0]  set_year;
  } rtc_in_t;

  typedef struct packed {
    logic [HourWidth-1:0]  hour;
    logic [MinWidth-1:0]   minute;
    logic [SecWidth-1:0]   second;
    logic [DayWidth-1:0]   day;
    logic [MonthWidth-1:0] month;
    logic [YearWidth-1:0]  year;
    logic                  day_changed;
  } rtc_out_t;

  typedef logic [TpsWidth-1:0] rtc_cfg_t;

  // days in month; Apr, Jun, Sep and Nov count as 30, Feb as 29 or 28, every other code as 31
  function automatic logic [DayWidth-1:0] month_length(
    input logic [MonthWidth-1:0] month,
    input logic [YearWidth-1:0]  year
  );
    logic [DayWidth-1:0] len;
    len = 5'd31;
    if (month == MonthApr || month == MonthJun || month == MonthSep || month == MonthNov) begin
      len = 5'd30;
    end else if (month == MonthFeb) begin
      len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

endpackage

[rtl/rtc_stream_if.sv]
// rtc_stream_if: valid/ready channel carrying one payload of a given type
// no dependencies; payload type set per instance

interface rtc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/rtc_time_and_calendar_core.sv]
// rtc_time_and_calendar_core: time-of-day and calendar counter with command stream
// depends on rtc_pkg and rtc_stream_if
//
// usage:
//   in_i carries commands: a tick, a time load or a date load. every transfer
//   on in_i yields exactly one transfer on out_o with the time and date after
//   that command and a flag set when a tick crossed midnight.
//   cfg_i writes the tick count per second; it is always ready and should be
//   written only while no command is in flight.
// output: the result is registered; out_o goes valid in the cycle after the input transfer.
// throughput: one command per cycle while out_o is ready; the whole update is a
//   single pass of increment and carry logic between the state registers and the
//   result register.
// stall: the result register holds while out_o is not ready; in_i stays ready
//   whenever the result register is empty or being drained that cycle.
// reset: time 00:00:00, date day 26 month 7 year 25, sub-second count 0,
//   1000 ticks per second, result register empty.

module rtc_time_and_calendar_core
  import rtc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  rtc_stream_if.sink         in_i,
  rtc_stream_if.sink         cfg_i,
  rtc_stream_if.source       out_o
);

  logic [TpsWidth-1:0]   tps_q;
  logic [TpsWidth-1:0]   sub_q, sub_d;
  logic [SecWidth-1:0]   sec_q, sec_d;
  logic [MinWidth-1:0]   min_q, min_d;
  logic [HourWidth-1:0]  hour_q, hour_d;
  logic [DayWidth-1:0]   day_q, day_d;
  logic [MonthWidth-1:0] month_q, month_d;
  logic [YearWidth-1:0]  year_q, year_d;
  logic                  rolled;

  logic                  out_valid_q;
  rtc_out_t              out_q, out_d;

  logic                  in_xfer;
  rtc_in_t               cmd;
  logic [TpsWidth:0]     sub_inc;
  logic                  sec_done;

  assign cmd = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign sub_inc = {1'b0, sub_q} + {{TpsWidth{1'b0}}, 1'b1};
  assign sec_done = (sub_inc >= {1'b0, tps_q});

  always_comb begin
    sub_d = sub_q;
    sec_d = sec_q;
    min_d = min_q;
    hour_d = hour_q;
    day_d = day_q;
    month_d = month_q;
    year_d = year_q;
    rolled = 1'b0;
    unique case (cmd.func)
      FuncTick: begin
        if (sec_done) begin
          sub_d = '0;
          if (sec_q < LastSec) begin
            sec_d = sec_q + 1'b1;
          end else begin
            sec_d = '0;
            if (min_q < LastMin) begin
              min_d = min_q + 1'b1;
            end else begin
              min_d = '0;
              if (hour_q < LastHour) begin
                hour_d = hour_q + 1'b1;
              end else begin
                hour_d = '0;
                rolled = 1'b1;
                if (day_q >= month_length(month_q, year_q)) begin
                  day_d = 5'd1;
                  if (month_q >= LastMonth) begin
                    month_d = 4'd1;
                    year_d = (year_q >= LastYear) ? '0 : year_q + 1'b1;
                  end else begin
                    month_d = month_q + 1'b1;
                  end
                end else begin
                  day_d = day_q + 1'b1;
                end
              end
            end
          end
        end else begin
          sub_d = sub_inc[TpsWidth-1:0];
        end
      end
      FuncSetTime: begin
        hour_d = cmd.set_hour;
        min_d = cmd.set_minute;
        sec_d = cmd.set_second;
        sub_d = '0;
      end
      FuncSetDate: begin
        day_d = cmd.set_day;
        month_d = cmd.set_month;
        year_d = cmd.set_year;
      end
      default: begin
      end
    endcase

    out_d.hour = hour_d;
    out_d.minute = min_d;
    out_d.second = sec_d;
    out_d.day = day_d;
    out_d.month = month_d;
    out_d.year = year_d;
    out_d.day_changed = rolled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TpsReset;
      sub_q <= '0;
      sec_q <= '0;
      min_q <= '0;
      hour_q <= '0;
      day_q <= DayReset;
      month_q <= MonthReset;
      year_q <= YearReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        tps_q <= cfg_i.payload;
      end
      if (in_xfer) begin
        sub_q <= sub_d;
        sec_q <= sec_d;
        min_q <= min_d;
        hour_q <= hour_d;
        day_q <= day_d;
        month_q <= month_d;
        year_q <= year_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

endmodule

[sim/tb_rtc_time_and_calendar_core.sv]
`timescale 1ns / 100ps
// tb_rtc_time_and_calendar_core: self-checking bench for the clock and calendar core
// depends on rtc_pkg, rtc_stream_if and rtc_time_and_calendar_core; drives directed
// and random commands with random gaps and stalls, checks each reading in order

module tb_rtc_time_and_calendar_core;
  import rtc_pkg::*;

  localparam logic [1:0] FuncUnused = 2'd3;

  logic clk_i;
  logic rst_ni;

  rtc_stream_if #(.payload_t(rtc_in_t))  in_if ();
  rtc_stream_if #(.payload_t(rtc_cfg_t)) cfg_if ();
  rtc_stream_if #(.payload_t(rtc_out_t)) out_if ();

  rtc_time_and_calendar_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .cfg_i  (cfg_if),
    .out_o  (out_if)
  );

  rtc_in_t  commands_q[$];
  rtc_out_t readings_q[$];
  int       err_count = 0;
  bit       quiet = 1'b0;
  int       in_gap = 0;
  int       out_stall = 0;

  // shadow of the clock and calendar state
  logic [TpsWidth-1:0]   clk_rate;
  logic [TpsWidth-1:0]   clk_sub;
  logic [SecWidth-1:0]   clk_sec;
  logic [MinWidth-1:0]   clk_min;
  logic [HourWidth-1:0]  clk_hour;
  logic [DayWidth-1:0]   cal_day;
  logic [MonthWidth-1:0] cal_month;
  logic [YearWidth-1:0]  cal_year;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("tb_rtc_time_and_calendar_core: errors");
    $finish;
  end

  function automatic int days_in(input logic [MonthWidth-1:0] mon,
                                 input logic [YearWidth-1:0] yr);
    case (mon)
      MonthApr, MonthJun, MonthSep, MonthNov: return 30;
      MonthFeb: return (yr % 4 == 0) ? 29 : 28;
      default: return 31;
    endcase
  endfunction

  task automatic step_date();
    if (cal_day >= days_in(cal_month, cal_year)) begin
      cal_day = 5'd1;
      if (cal_month >= LastMonth) begin
        cal_month = 4'd1;
        cal_year = (cal_year >= LastYear) ? '0 : cal_year + 7'd1;
      end else begin
        cal_month = cal_month + 4'd1;
      end
    end else begin
      cal_day = cal_day + 5'd1;
    end
  endtask

  task automatic step_second(output logic midnight);
    midnight = 1'b0;
    if (clk_sec < LastSec) begin
      clk_sec = clk_sec + 6'd1;
    end else begin
      clk_sec = '0;
      if (clk_min < LastMin) begin
        clk_min = clk_min + 6'd1;
      end else begin
        clk_min = '0;
        if (clk_hour < LastHour) begin
          clk_hour = clk_hour + 5'd1;
        end else begin
          clk_hour = '0;
          step_date();
          midnight = 1'b1;
        end
      end
    end
  endtask

  task automatic advance_clock(input rtc_in_t cmd, output rtc_out_t reading);
    logic [TpsWidth:0] next_sub;
    logic              midnight;
    midnight = 1'b0;
    case (cmd.func)
      FuncTick: begin
        next_sub = {1'b0, clk_sub} + 1'b1;
        if (next_sub >= {1'b0, clk_rate}) begin
          clk_sub = '0;
          step_second(midnight);
        end else begin
          clk_sub = next_sub[TpsWidth-1:0];
        end
      end
      FuncSetTime: begin
        clk_hour = cmd.set_hour;
        clk_min = cmd.set_minute;
        clk_sec = cmd.set_second;
        clk_sub = '0;
      end
      FuncSetDate: begin
        cal_day = cmd.set_day;
        cal_month = cmd.set_month;
        cal_year = cmd.set_year;
      end
      default: ;
    endcase
    reading.hour = clk_hour;
    reading.minute = clk_min;
    reading.second = clk_sec;
    reading.day = cal_day;
    reading.month = cal_month;
    reading.year = cal_year;
    reading.day_changed = midnight;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  task automatic mismatch(input string field, input int want, input int got);
    $error("%s: expected %0d, got %0d", field, want, got);
    err_count++;
  endtask

  always @(posedge clk_i) begin : cmd_driver
    rtc_out_t reading;
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        advance_clock(in_if.payload, reading);
        readings_q.push_back(reading);
      end
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (commands_q.size() > 0) begin
          in_if.payload <= commands_q.pop_front();
          in_if.valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : reading_monitor
    rtc_out_t want;
    rtc_out_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.payload;
        if (readings_q.size() == 0) begin
          $error("unexpected transfer on the result channel");
          err_count++;
        end else begin
          want = readings_q.pop_front();
          if (want.hour !== got.hour) mismatch("hour", int'(want.hour), int'(got.hour));
          if (want.minute !== got.minute) begin
            mismatch("minute", int'(want.minute), int'(got.minute));
          end
          if (want.second !== got.second) begin
            mismatch("second", int'(want.second), int'(got.second));
          end
          if (want.day !== got.day) mismatch("day", int'(want.day), int'(got.day));
          if (want.month !== got.month) mismatch("month", int'(want.month), int'(got.month));
          if (want.year !== got.year) mismatch("year", int'(want.year), int'(got.year));
          if (want.day_changed !== got.day_changed) begin
            mismatch("day_changed", int'(want.day_changed), int'(got.day_changed));
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = pick_gap();
      end
    end
  end

  function automatic rtc_in_t noise_cmd(input logic [1:0] func);
    logic [63:0] r;
    rtc_in_t     c;
    r = {$urandom, $urandom};
    c = r[$bits(rtc_in_t)-1:0];
    c.func = func;
    return c;
  endfunction

  task automatic send_ticks(input int n);
    repeat (n) commands_q.push_back(noise_cmd(FuncTick));
  endtask

  task automatic send_time(input int h, input int m, input int s);
    rtc_in_t c;
    c = noise_cmd(FuncSetTime);
    c.set_hour = h[HourWidth-1:0];
    c.set_minute = m[MinWidth-1:0];
    c.set_second = s[SecWidth-1:0];
    commands_q.push_back(c);
  endtask

  task automatic send_date(input int d, input int m, input int y);
    rtc_in_t c;
    c = noise_cmd(FuncSetDate);
    c.set_day = d[DayWidth-1:0];
    c.set_month = m[MonthWidth-1:0];
    c.set_year = y[YearWidth-1:0];
    commands_q.push_back(c);
  endtask

  // checked between edges so that no transfer set up at the last edge is missed
  task automatic wait_drained();
    do @(negedge clk_i);
    while (commands_q.size() != 0 || in_if.valid || readings_q.size() != 0 || out_if.valid);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic write_rate(input logic [TpsWidth-1:0] rate);
    wait_drained();
    cfg_if.payload <= rate;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    clk_rate = rate;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_phase(input int n);
    int r;
    int m;
    int y;
    int d;
    quiet = ($urandom_range(0, 3) == 0);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        send_ticks(1);
      end else if (r < 78) begin
        r = $urandom_range(0, 9);
        if (r < 7) send_time(23, 59, $urandom_range(52, 59));
        else if (r < 9) send_time($urandom_range(0, 23), $urandom_range(0, 59),
                                  $urandom_range(0, 59));
        else send_time($urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
      end else if (r < 90) begin
        r = $urandom_range(0, 19);
        m = $urandom_range(1, 12);
        y = $urandom_range(0, 99);
        if (r < 12) begin
          d = days_in(m[MonthWidth-1:0], y[YearWidth-1:0]) - 2 + $urandom_range(0, 3);
          if (d > 31) d = 31;
          send_date(d, m, y);
        end else if (r < 17) begin
          send_date($urandom_range(1, 31), m, y);
        end else begin
          send_date($urandom_range(0, 31), $urandom_range(0, 15), $urandom_range(0, 127));
        end
      end else if (r < 96) begin
        commands_q.push_back(noise_cmd(FuncUnused));
      end else begin
        send_ticks($urandom_range(2, 6));
      end
    end
  endtask

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.payload = '0;
    cfg_if.valid = 1'b0;
    cfg_if.payload = '0;
    out_if.ready = 1'b0;
    clk_rate = TpsReset;
    clk_sub = '0;
    clk_sec = '0;
    clk_min = '0;
    clk_hour = '0;
    cal_day = DayReset;
    cal_month = MonthReset;
    cal_year = YearReset;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset rate, unused code shows reset state, count left part way
    commands_q.push_back(noise_cmd(FuncUnused));
    send_time(23, 59, 59);
    send_date(31, 12, 99);
    send_ticks(2);
    // rate lowered below the count: next tick ends the second, year wraps
    write_rate(16'd2);
    send_ticks(1);
    // zero rate, every tick is a second
    write_rate(16'd0);
    send_date(28, 2, 4);
    send_time(23, 59, 59);
    send_ticks(1);
    send_time(23, 59, 59);
    send_ticks(1);
    send_date(28, 2, 1);
    send_time(23, 59, 59);
    send_ticks(1);
    send_date(30, 4, 10);
    send_time(23, 59, 59);
    send_ticks(1);
    // out-of-range loads
    send_date(0, 13, 120);
    send_time(31, 63, 63);
    send_ticks(1);
    send_date(31, 15, 127);
    send_time(23, 59, 59);
    send_ticks(1);
    send_time(0, 0, 0);
    send_date(1, 1, 0);

    write_rate(16'hFFFF);
    random_phase(60);
    write_rate(16'd1);
    random_phase(120);
    write_rate(16'd2);
    random_phase(100);
    write_rate(16'd3);
    random_phase(100);
    write_rate(16'($urandom_range(4, 12)));
    random_phase(100);
    write_rate(16'd1);
    random_phase(110);
    write_rate(16'($urandom_range(1, 6)));
    random_phase(100);

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_rtc_time_and_calendar_core: clean");
    end else begin
      $display("tb_rtc_time_and_calendar_core: errors");
    end
    $finish;
  end

endmodule
